/* rtl/core/hlm_pkg.sv */
// hlm_pkg: widths, limits and shared types of the mean Huber loss block.
// No dependencies; the front end, divider and top level refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package hlm_pkg;

  localparam int DATA_W   = 16;  // prediction / target, signed Q8.8
  localparam int DELTA_W  = 15;  // Huber threshold, unsigned Q7.8
  localparam int ERR_W    = 17;  // prediction - target
  localparam int ABS_W    = 16;  // |error| never exceeds 65535
  localparam int OPB_W    = 17;  // second multiplier operand
  localparam int PROD_W   = 33;  // ABS_W x OPB_W
  localparam int TERM_W   = 32;  // product halved
  localparam int SUM_W    = 50;  // running loss sum
  localparam int MEAN_W   = 31;  // mean loss, unsigned Q15.16
  localparam int ICOUNT_W = 17;  // item count field on the result
  localparam int STEP_W   = 6;   // divider step counter, holds SUM_W

  localparam logic [DELTA_W-1:0] DELTA_RESET = 15'd256;  // 1.0
  localparam logic [SUM_W-1:0]   SUM_MAX     = {SUM_W{1'b1}};
  localparam logic [MEAN_W-1:0]  MEAN_MAX    = {MEAN_W{1'b1}};

  typedef logic signed [DATA_W-1:0] sample_t;
  typedef logic [DELTA_W-1:0]       delta_t;
  typedef logic [SUM_W-1:0]         sum_t;
  typedef logic [MEAN_W-1:0]        mean_t;

endpackage
`default_nettype wire

/* rtl/core/hlm_front.sv */
// hlm_front: accepts pairs, forms the Huber term and accumulates sets.
// Four stages: error, operand select, multiply, accumulate. Uses hlm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hlm_front #(
  parameter int unsigned MAX_ITEMS = 65536,
  parameter int CNT_W = 17
) (
  input  wire                    clk,
  input  wire                    rst,
  input  hlm_pkg::delta_t        delta,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  hlm_pkg::sample_t       prediction,
  input  hlm_pkg::sample_t       target,
  input  wire                    last,
  output logic                   set_valid,
  input  wire                    set_ready,
  output hlm_pkg::sum_t          set_sum,
  output logic [CNT_W-1:0]       set_count,
  output logic                   set_ovf
);

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ITEMS);

  // stage registers
  logic                                  v1, l1;
  logic signed [hlm_pkg::ERR_W-1:0]      e1;
  logic                                  v2, l2;
  logic [hlm_pkg::ABS_W-1:0]             a2;
  logic [hlm_pkg::OPB_W-1:0]             b2;
  logic                                  v3, l3;
  logic [hlm_pkg::PROD_W-1:0]            prod3;

  // accumulator
  hlm_pkg::sum_t      sum, sum_next;
  logic [CNT_W-1:0]   count, count_next;
  logic               ovf, ovf_next;

  logic                                  en, fire, keep;
  logic signed [hlm_pkg::ERR_W-1:0]      e_neg;
  logic [hlm_pkg::ABS_W-1:0]             ae;
  logic                                  quad;
  logic [hlm_pkg::TERM_W-1:0]            term;
  logic [hlm_pkg::SUM_W:0]               sum_add;

  // whole pipeline holds while a finished set waits for queue space
  assign en       = !(v3 && l3 && !set_ready);
  assign in_ready = en;
  assign fire     = v3 && en;

  // absolute error and branch select
  always_comb begin
    e_neg = -e1;
    ae    = e1[hlm_pkg::ERR_W-1] ? e_neg[hlm_pkg::ABS_W-1:0] : e1[hlm_pkg::ABS_W-1:0];
    quad  = {1'b0, ae} <= {2'b00, delta};
  end

  // term and saturating accumulate
  always_comb begin
    term       = prod3[hlm_pkg::PROD_W-1:1];
    keep       = count < MAX_CNT;
    sum_add    = {1'b0, sum} + (hlm_pkg::SUM_W+1)'(term);
    sum_next   = sum;
    count_next = count;
    ovf_next   = ovf;
    if (keep) begin
      sum_next   = sum_add[hlm_pkg::SUM_W] ? hlm_pkg::SUM_MAX : sum_add[hlm_pkg::SUM_W-1:0];
      count_next = count + 1'b1;
    end else begin
      ovf_next = 1'b1;
    end
  end

  assign set_valid = fire && l3;
  assign set_sum   = sum_next;
  assign set_count = count_next;
  assign set_ovf   = ovf_next;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      sum   <= '0;
      count <= '0;
      ovf   <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      if (fire) begin
        if (l3) begin
          sum   <= '0;
          count <= '0;
          ovf   <= 1'b0;
        end else begin
          sum   <= sum_next;
          count <= count_next;
          ovf   <= ovf_next;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      e1 <= {prediction[hlm_pkg::DATA_W-1], prediction} - {target[hlm_pkg::DATA_W-1], target};
      l1 <= last;
      // quadratic: ae*ae, linear: delta*(2ae - delta)
      if (quad) begin
        a2 <= ae;
        b2 <= {1'b0, ae};
      end else begin
        a2 <= {1'b0, delta};
        b2 <= {ae, 1'b0} - {2'b00, delta};
      end
      l2    <= l1;
      prod3 <= a2 * b2;
      l3    <= l2;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/hlm_queue.sv */
// hlm_queue: two-entry queue of finished sets between front and divider.
// Payload is an opaque vector; no package items needed beyond the net setup.
`timescale 1ns / 1ps
`default_nettype none
module hlm_queue #(
  parameter int W = 68
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          wr_valid,
  output logic         wr_ready,
  input  wire  [W-1:0] wr_data,
  output logic         rd_valid,
  input  wire          rd_ready,
  output logic [W-1:0] rd_data
);

  logic [W-1:0] mem [2];
  logic         wr_ptr, rd_ptr;
  logic [1:0]   fill;
  logic         push, pop;

  assign wr_ready = fill != 2'd2;
  assign rd_valid = fill != 2'd0;
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      if (push && !pop)      fill <= fill + 2'd1;
      else if (pop && !push) fill <= fill - 2'd1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_data;
  end

endmodule
`default_nettype wire

/* rtl/core/hlm_divider.sv */
// hlm_divider: back end; restoring divide of the set sum by its count,
// one quotient bit per cycle, then saturation into the output register. Uses hlm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hlm_divider #(
  parameter int CNT_W = 17
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                set_valid,
  output logic                               set_ready,
  input  hlm_pkg::sum_t                      set_sum,
  input  wire  [CNT_W-1:0]                   set_count,
  input  wire                                set_ovf,
  output logic                               out_valid,
  input  wire                                out_ready,
  output hlm_pkg::mean_t                     mean_loss,
  output logic [hlm_pkg::ICOUNT_W-1:0]       item_count,
  output logic                               overflow
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;
  localparam int CX_W = (CNT_W > hlm_pkg::ICOUNT_W) ? CNT_W : hlm_pkg::ICOUNT_W;

  logic [1:0]                  state;
  logic [hlm_pkg::STEP_W-1:0]  steps;
  hlm_pkg::sum_t               quot;
  logic [CNT_W-1:0]            rem, div;
  logic                        ovf_h;

  logic [CNT_W:0]              rem_sh, rem_sub;
  logic                        ge, load_out;
  hlm_pkg::mean_t              mean_sat;
  logic [CX_W-1:0]             count_x;

  assign set_ready = state == ST_IDLE;
  assign load_out  = (state == ST_DONE) && (!out_valid || out_ready);

  // one restoring step
  always_comb begin
    rem_sh  = {rem, quot[hlm_pkg::SUM_W-1]};
    rem_sub = rem_sh - {1'b0, div};
    ge      = rem_sh >= {1'b0, div};
  end

  // saturate quotient; an empty set reads as zero
  always_comb begin
    count_x = CX_W'(div);
    if (div == '0)
      mean_sat = '0;
    else if (quot[hlm_pkg::SUM_W-1:hlm_pkg::MEAN_W] != '0)
      mean_sat = hlm_pkg::MEAN_MAX;
    else
      mean_sat = quot[hlm_pkg::MEAN_W-1:0];
  end

  // sequencer and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      steps     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_out)
        out_valid <= 1'b1;
      else if (out_ready)
        out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (set_valid) begin
            state <= ST_RUN;
            steps <= hlm_pkg::STEP_W'(hlm_pkg::SUM_W);
          end
        end
        ST_RUN: begin
          steps <= steps - 1'b1;
          if (steps == hlm_pkg::STEP_W'(1)) state <= ST_DONE;
        end
        ST_DONE: begin
          if (load_out) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && set_valid) begin
      quot  <= set_sum;
      rem   <= '0;
      div   <= set_count;
      ovf_h <= set_ovf;
    end else if (state == ST_RUN) begin
      quot <= {quot[hlm_pkg::SUM_W-2:0], ge};
      rem  <= ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
    end
    if (load_out) begin
      mean_loss  <= mean_sat;
      item_count <= count_x[hlm_pkg::ICOUNT_W-1:0];
      overflow   <= ovf_h;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/huber_loss_mean.sv */
// huber_loss_mean: top level; delta register, front end, set queue, divider.
// Depends on hlm_pkg, hlm_front, hlm_queue and hlm_divider.
//
// Mean Huber loss over sets of signed Q8.8 prediction/target pairs. The front
// end takes one pair per clock, unless a finished set waits for queue space,
// and adds its Q16.16 term to the set sum after the error, operand and product
// registers; the pair with tlast closes the set. Each closed set is divided by
// its pair count in a bit-serial divider of 50 steps, busy until its result
// is loaded. Two closed sets can wait in the queue; short sets eventually
// stall input until the divider catches up. Pairs beyond MAX_ITEMS in a set
// are dropped and flagged in tuser. Write delta only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module huber_loss_mean #(
  parameter int unsigned MAX_ITEMS = 65536
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [14:0] cfg_data,       // delta
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [31:0] s_axis_tdata,   // [15:0] prediction, [31:16] target
  input  wire         s_axis_tlast,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [30:0] mean_loss, [47:31] item_count
  output logic [0:0]  m_axis_tuser    // [0] overflow
);

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int SET_W = hlm_pkg::SUM_W + CNT_W + 1;

  hlm_pkg::delta_t  delta;
  logic             f_valid, f_ready, q_valid, q_ready;
  hlm_pkg::sum_t    f_sum, q_sum;
  logic [CNT_W-1:0] f_count, q_count;
  logic             f_ovf, q_ovf;
  logic [SET_W-1:0] q_data;

  hlm_pkg::mean_t                 mean_loss;
  logic [hlm_pkg::ICOUNT_W-1:0]   item_count;
  logic                           overflow;

  // threshold register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      delta <= hlm_pkg::DELTA_RESET;
    end else if (cfg_valid) begin
      delta <= cfg_data;
    end
  end

  hlm_front #(.MAX_ITEMS(MAX_ITEMS), .CNT_W(CNT_W)) u_front (
    .clk        (clk),
    .rst        (rst),
    .delta      (delta),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .prediction (s_axis_tdata[15:0]),
    .target     (s_axis_tdata[31:16]),
    .last       (s_axis_tlast),
    .set_valid  (f_valid),
    .set_ready  (f_ready),
    .set_sum    (f_sum),
    .set_count  (f_count),
    .set_ovf    (f_ovf)
  );

  hlm_queue #(.W(SET_W)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  ({f_ovf, f_count, f_sum}),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  assign q_sum   = q_data[hlm_pkg::SUM_W-1:0];
  assign q_count = q_data[hlm_pkg::SUM_W +: CNT_W];
  assign q_ovf   = q_data[SET_W-1];

  hlm_divider #(.CNT_W(CNT_W)) u_divider (
    .clk        (clk),
    .rst        (rst),
    .set_valid  (q_valid),
    .set_ready  (q_ready),
    .set_sum    (q_sum),
    .set_count  (q_count),
    .set_ovf    (q_ovf),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .mean_loss  (mean_loss),
    .item_count (item_count),
    .overflow   (overflow)
  );

  assign m_axis_tdata = {item_count, mean_loss};
  assign m_axis_tuser = overflow;

endmodule
`default_nettype wire
